// File: src/phvp_pkg.sv
// Shared types, codes and token tables for the Privacy header value parser.
// Used by phvp_match and privacy_header_value_parser; no dependencies.
package phvp_pkg;

  localparam int NUM_TOKENS = 7;

  // Parse phases.
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_TOKEN = 3'd1;
  localparam logic [2:0] PH_DELIM = 3'd2;
  localparam logic [2:0] PH_POST  = 3'd3;
  localparam logic [2:0] PH_SEMI  = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BADVAL  = 3'd2;
  localparam logic [2:0] ST_NOSEMI  = 3'd3;
  localparam logic [2:0] ST_NOAFTER = 3'd4;
  localparam logic [2:0] ST_MIXED   = 3'd5;

  // Token mask bits.
  localparam logic [NUM_TOKENS-1:0] ALL_TOKENS = 7'h7F;
  localparam logic [NUM_TOKENS-1:0] NONE_BIT   = 7'h10;

  localparam logic [7:0] CHR_SEMI = 8'h3B;
  localparam logic [7:0] CHR_NUL  = 8'h00;

  typedef logic [NUM_TOKENS-1:0] tok_mask_t;

  typedef struct packed {
    tok_mask_t live;
    tok_mask_t done;
  } match_t;

  // Length of each token in characters.
  function automatic logic [3:0] tok_len(input logic [2:0] idx);
    logic [3:0] len;
    case (idx)
      3'd0: len = 4'd8;
      3'd1: len = 4'd6;
      3'd2: len = 4'd7;
      3'd3: len = 4'd2;
      3'd4: len = 4'd4;
      3'd5: len = 4'd7;
      3'd6: len = 4'd4;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Character at position pos of a token, lower case. Only meaningful
  // when pos is below the token length.
  function automatic logic [7:0] tok_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [63:0] text;
    logic [2:0]  sel;
    case (idx)
      3'd0: text = 64'("critical");
      3'd1: text = 64'("header");
      3'd2: text = 64'("history");
      3'd3: text = 64'("id");
      3'd4: text = 64'("none");
      3'd5: text = 64'("session");
      3'd6: text = 64'("user");
      default: text = '0;
    endcase
    // Strings are right aligned, so the first character sits highest.
    sel = 3'(tok_len(idx) - 4'd1 - {1'b0, pos});
    return text[{sel, 3'b000} +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

endpackage

// File: src/privacy_header_value_parser.sv
// Top level of the Privacy header value parser.
// Depends on phvp_pkg and phvp_match.
//
// The block takes a Privacy header body one byte per request, with the last
// byte flagged, and on the last byte delivers one result: a status code and a
// 7-bit mask of the tokens seen (critical, header, history, id, none, session,
// user). It takes a byte every cycle but for the stall below; the parse step
// for a byte is shallow compare logic from the byte port into the parse state
// registers. A body's result appears in an output register the cycle after
// its last byte is taken. While that result waits unread, no byte is taken;
// bytes are taken again from the cycle in which the result is read. Bytes
// that follow the first error up to the last byte are consumed and ignored.
module privacy_header_value_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [6:0] out_privacy_bits
);
  import phvp_pkg::*;

  logic [2:0] phase_r, phase_nxt;
  tok_mask_t  cand_r, cand_nxt;
  logic [3:0] pos_r, pos_nxt;
  tok_mask_t  acc_r, acc_nxt;
  logic [2:0] err_r, err_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  tok_mask_t  out_bits_r, out_bits_nxt;

  match_t     match;
  logic       in_fire;
  logic       is_sp;
  logic       do_match;
  logic [2:0] step_phase;
  logic [2:0] step_err;
  tok_mask_t  step_cand;
  logic [3:0] step_pos;
  tok_mask_t  step_acc;
  logic [2:0] status;

  phvp_match u_match (
    .text_byte  (in_text_byte),
    .candidates (cand_r),
    .position   (pos_r),
    .result     (match)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_sp    = is_space(in_text_byte);

  // Parse step for one byte.
  always_comb begin
    step_phase = phase_r;
    step_err   = err_r;
    step_cand  = cand_r;
    step_pos   = pos_r;
    step_acc   = acc_r;
    do_match   = 1'b0;
    case (phase_r)
      PH_LEAD, PH_SEMI: do_match = !is_sp;
      PH_TOKEN:         do_match = 1'b1;
      PH_DELIM: begin
        if (is_sp) begin
          step_phase = PH_POST;
        end else if (in_text_byte == CHR_SEMI) begin
          step_phase = PH_SEMI;
        end else if (in_text_byte == CHR_NUL) begin
          step_phase = PH_ERR;
          step_err   = ST_NOSEMI;
        end else begin
          step_phase = PH_ERR;
          step_err   = ST_BADVAL;
        end
      end
      PH_POST: begin
        if (in_text_byte == CHR_SEMI) begin
          step_phase = PH_SEMI;
        end else if (!is_sp) begin
          step_phase = PH_ERR;
          step_err   = ST_NOSEMI;
        end
      end
      default: ;
    endcase
    if (do_match) begin
      if (match.live == '0) begin
        step_phase = PH_ERR;
        step_err   = ST_BADVAL;
      end else if (match.done != '0) begin
        step_acc   = acc_r | match.done;
        step_cand  = ALL_TOKENS;
        step_pos   = 4'd0;
        step_phase = PH_DELIM;
      end else begin
        step_cand  = match.live;
        step_pos   = pos_r + 4'd1;
        step_phase = PH_TOKEN;
      end
    end
  end

  // Final status once the last byte has been folded in.
  always_comb begin
    case (step_phase)
      PH_ERR:   status = step_err;
      PH_LEAD:  status = ST_EMPTY;
      PH_TOKEN: status = ST_BADVAL;
      PH_SEMI:  status = ST_NOAFTER;
      default: begin
        if (((step_acc & NONE_BIT) != '0) && ((step_acc & ~NONE_BIT) != '0)) begin
          status = ST_MIXED;
        end else begin
          status = ST_OK;
        end
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    cand_nxt       = cand_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_bits_nxt   = out_bits_r;
    if (in_fire) begin
      if (in_last_byte) begin
        phase_nxt      = PH_LEAD;
        cand_nxt       = ALL_TOKENS;
        pos_nxt        = 4'd0;
        acc_nxt        = '0;
        err_nxt        = ST_OK;
        out_valid_nxt  = 1'b1;
        out_status_nxt = status;
        out_bits_nxt   = (status == ST_OK) ? step_acc : '0;
      end else begin
        phase_nxt = step_phase;
        cand_nxt  = step_cand;
        pos_nxt   = step_pos;
        acc_nxt   = step_acc;
        err_nxt   = step_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      cand_r      <= ALL_TOKENS;
      pos_r       <= 4'd0;
      acc_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cand_r      <= cand_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_bits_r   <= out_bits_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_privacy_bits = out_bits_r;

  // A failed body never reports any token bits.
  a_err_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_bits_r == '0))
    else $error("error result carries token bits");

  // The error phase always has a recorded error code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR) |-> (err_r != ST_OK))
    else $error("error phase without error code");

  // The token position never runs past the longest token.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < 4'd8)
    else $error("token position out of range");

  // A body's last byte leaves the parser ready for a fresh body.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> (phase_r == PH_LEAD) && (pos_r == 4'd0) &&
    (acc_r == '0) && (cand_r == ALL_TOKENS) && out_valid_r)
    else $error("parser did not restart after last byte");

endmodule

// File: src/phvp_match.sv
// Token matcher: compares one byte against every live token at the current
// position. Depends on phvp_pkg.
module phvp_match (
  input  logic [7:0]        text_byte,
  input  phvp_pkg::tok_mask_t candidates,
  input  logic [3:0]        position,
  output phvp_pkg::match_t  result
);
  import phvp_pkg::*;

  logic [7:0] lower;

  assign lower = (text_byte >= 8'h41 && text_byte <= 8'h5A) ? text_byte + 8'h20 : text_byte;

  always_comb begin
    result = '0;
    for (int i = 0; i < NUM_TOKENS; i++) begin
      if (candidates[i] && (position < tok_len(3'(i))) &&
          (tok_char(3'(i), position[2:0]) == lower)) begin
        result.live[i] = 1'b1;
        if (position + 4'd1 == tok_len(3'(i))) begin
          result.done[i] = 1'b1;
        end
      end
    end
  end

endmodule

// File: tb/sv/privacy_header_value_parser_tb.sv
`timescale 1ns / 1ps
// Testbench for privacy_header_value_parser: directed and random header bodies,
// checked against a byte-level parse predictor. Depends on phvp_pkg and the RTL.
module privacy_header_value_parser_tb;
  import phvp_pkg::*;

  localparam int BODY_BYTE_TARGET = 1900;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int MAX_PRINTED      = 30;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] bits;
  } verdict_t;

  typedef enum int {
    FLAW_NONE, FLAW_BYTE, FLAW_TRAIL_SEMI, FLAW_CUT, FLAW_NUL, FLAW_NO_SEMI
  } flaw_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [6:0] out_privacy_bits;

  // Predictor state for the body being parsed.
  logic [2:0] phase_q;
  tok_mask_t  live_set;
  logic [3:0] char_idx;
  tok_mask_t  seen_mask;
  logic [2:0] err_code;

  verdict_t   expected_verdicts[$];
  verdict_t   want;
  logic [7:0] body_bytes[$];
  string      token_text[NUM_TOKENS] = '{"critical", "header", "history", "id",
                                         "none", "session", "user"};

  int  error_count = 0;
  int  bytes_sent = 0;
  int  bodies_sent = 0;
  int  cycle_count = 0;
  int  status_seen[8];
  bit  idle_on = 1'b1;
  bit  receiver_hold = 1'b0;
  event hold_off_ev;

  privacy_header_value_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_privacy_bits(out_privacy_bits)
  );

  always #5 clk = ~clk;

  function automatic bit is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  task automatic report(input string msg);
    if (error_count < MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_parse();
    phase_q   = PH_LEAD;
    live_set  = ALL_TOKENS;
    char_idx  = 4'd0;
    seen_mask = '0;
    err_code  = ST_OK;
  endtask

  task automatic flag_error(input logic [2:0] code);
    err_code = code;
    phase_q  = PH_ERR;
  endtask

  // Narrows the live token set by one character, case folded.
  task automatic advance_token(input logic [7:0] b);
    logic [7:0] lc;
    tok_mask_t  hit;
    tok_mask_t  finished;
    string      word;
    lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    hit = '0;
    finished = '0;
    for (int i = 0; i < NUM_TOKENS; i++) begin
      word = token_text[i];
      if (live_set[i] && char_idx < word.len() && word[char_idx] == lc) begin
        hit[i] = 1'b1;
        if (char_idx + 1 == word.len())
          finished[i] = 1'b1;
      end
    end
    if (hit == '0) begin
      flag_error(ST_BADVAL);
    end else if (finished != '0) begin
      seen_mask = seen_mask | finished;
      live_set  = ALL_TOKENS;
      char_idx  = 4'd0;
      phase_q   = PH_DELIM;
    end else begin
      live_set = hit;
      char_idx = char_idx + 4'd1;
      phase_q  = PH_TOKEN;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    case (phase_q)
      PH_LEAD, PH_SEMI: begin
        if (!is_blank(b))
          advance_token(b);
      end
      PH_TOKEN: advance_token(b);
      PH_DELIM: begin
        if (is_blank(b))
          phase_q = PH_POST;
        else if (b == CHR_SEMI)
          phase_q = PH_SEMI;
        else if (b == CHR_NUL)
          flag_error(ST_NOSEMI);
        else
          flag_error(ST_BADVAL);
      end
      PH_POST: begin
        if (b == CHR_SEMI)
          phase_q = PH_SEMI;
        else if (!is_blank(b))
          flag_error(ST_NOSEMI);
      end
      default: ;
    endcase
    if (last) begin
      case (phase_q)
        PH_ERR:   v.status = err_code;
        PH_LEAD:  v.status = ST_EMPTY;
        PH_TOKEN: v.status = ST_BADVAL;
        PH_SEMI:  v.status = ST_NOAFTER;
        default: begin
          v.status = ST_OK;
          if ((seen_mask & NONE_BIT) != '0 && (seen_mask & ~NONE_BIT) != '0)
            v.status = ST_MIXED;
        end
      endcase
      v.bits = (v.status == ST_OK) ? seen_mask : '0;
      expected_verdicts.push_back(v);
      clear_parse();
    end
  endtask

  // Offers one request and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_body();
    for (int k = 0; k < body_bytes.size(); k++)
      send_byte(body_bytes[k], k == body_bytes.size() - 1);
    bodies_sent++;
  endtask

  task automatic load_text(input string s);
    body_bytes.delete();
    for (int k = 0; k < s.len(); k++)
      body_bytes.push_back(s[k]);
  endtask

  // Lowers valid before letting time pass, so a taken byte is not resent.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic add_token(input int idx);
    string      word;
    logic [7:0] c;
    word = token_text[idx];
    for (int k = 0; k < word.len(); k++) begin
      c = word[k];
      if ($urandom_range(1))
        c = c - 8'h20;
      body_bytes.push_back(c);
    end
  endtask

  task automatic add_blanks(input int most);
    repeat ($urandom_range(0, most)) body_bytes.push_back(pick_blank());
  endtask

  // Builds a mostly legal token list, then sometimes breaks it in one place.
  task automatic build_token_list();
    int         count;
    int         at;
    flaw_kind_t flaw;
    body_bytes.delete();
    add_blanks(2);
    if ($urandom_range(99) < 15) begin
      add_token(4);
    end else begin
      count = $urandom_range(1, 3);
      for (int t = 0; t < count; t++) begin
        if (t != 0) begin
          add_blanks(1);
          body_bytes.push_back(CHR_SEMI);
          add_blanks(1);
        end
        add_token($urandom_range(NUM_TOKENS - 1));
      end
    end
    add_blanks(1);
    flaw = FLAW_NONE;
    if ($urandom_range(99) < 30)
      flaw = flaw_kind_t'($urandom_range(FLAW_BYTE, FLAW_NO_SEMI));
    case (flaw)
      FLAW_BYTE: begin
        at = $urandom_range(body_bytes.size() - 1);
        body_bytes[at] = 8'($urandom_range(255));
      end
      FLAW_TRAIL_SEMI: begin
        body_bytes.push_back(CHR_SEMI);
        add_blanks(2);
      end
      FLAW_CUT: begin
        if (body_bytes.size() > 1)
          void'(body_bytes.pop_back());
      end
      FLAW_NUL: body_bytes.push_back(CHR_NUL);
      FLAW_NO_SEMI: begin
        for (int k = 0; k < body_bytes.size(); k++) begin
          if (body_bytes[k] == CHR_SEMI) begin
            body_bytes[k] = pick_blank();
            break;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic build_noise();
    body_bytes.delete();
    repeat ($urandom_range(1, 6)) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic test_empty_body();
    body_bytes.delete();
    body_bytes.push_back(8'h20);
    body_bytes.push_back(8'h09);
    send_body();
  endtask

  task automatic test_token_match();
    load_text("Id");
    send_body();
  endtask

  task automatic test_bad_value();
    body_bytes.delete();
    body_bytes.push_back(8'hFF);
    send_body();
    load_text("hea");
    send_body();
    load_text("ida");
    send_body();
  endtask

  task automatic test_nul_follower();
    load_text("id");
    body_bytes.push_back(CHR_NUL);
    send_body();
  endtask

  task automatic test_missing_separator();
    load_text("id x");
    send_body();
  endtask

  task automatic test_trailing_semicolon();
    load_text("id;");
    send_body();
  endtask

  task automatic test_none_mixed();
    load_text("none;id");
    send_body();
  endtask

  // A stalled receiver holds back a result, and the byte input with it, while bodies keep coming.
  task automatic test_output_backpressure();
    -> hold_off_ev;
    repeat (6) begin
      build_token_list();
      send_body();
    end
    drain_results();
  endtask

  task automatic test_sender_pause();
    build_token_list();
    send_body();
    drain_results();
    build_token_list();
    send_body();
  endtask

  task automatic test_random_bodies();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < BODY_BYTE_TARGET) begin
      // The middle of the run goes without any idling on either side.
      idle_on = !((bytes_sent - start) > 600 && (bytes_sent - start) < 1100);
      if ($urandom_range(99) < 85)
        build_token_list();
      else
        build_noise();
      send_body();
    end
    idle_on = 1'b1;
  endtask

  always begin
    @(hold_off_ev);
    receiver_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_status]++;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result status=%0d bits=%h", out_status,
                         out_privacy_bits));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_status !== want.status)
          report($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_privacy_bits !== want.bits)
          report($sformatf("privacy_bits got %h want %h", out_privacy_bits,
                           want.bits));
      end
    end
    out_ready <= rst_n && !receiver_hold && !(idle_on && $urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_body();
    test_token_match();
    test_bad_value();
    test_nul_follower();
    test_missing_separator();
    test_trailing_semicolon();
    test_none_mixed();
    test_output_backpressure();
    test_random_bodies();
    test_sender_pause();
    drain_results();
    repeat (5) @(posedge clk);
    if (expected_verdicts.size() != 0)
      report($sformatf("%0d results never arrived", expected_verdicts.size()));
    $display("Parsed %0d bodies in %0d bytes, with output stalls and input gaps.",
             bodies_sent, bytes_sent);
    $display("Results by status: ok %0d, empty %0d, bad %0d, nosemi %0d, trailing %0d, mixed %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADVAL],
             status_seen[ST_NOSEMI], status_seen[ST_NOAFTER], status_seen[ST_MIXED]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
